// File: src/tpnc_pkg.sv
`timescale 1ns / 1ps
package tpnc_pkg;

   localparam int ADDR_W = 16;
   localparam int DEPTH = 1 << ADDR_W;
   localparam logic [15:0] GAIN_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      MODE_CORRECT     = 3'd0,
      MODE_ADD_HOT     = 3'd1,
      MODE_ADD_COLD    = 3'd2,
      MODE_MAKE_GAIN   = 3'd3,
      MODE_LOAD_FLAT   = 3'd4,
      MODE_MAKE_OFFSET = 3'd5,
      MODE_CLEAR       = 3'd6,
      MODE_UNUSED      = 3'd7
   } mode_type;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   typedef struct packed {
      mode_type    mode;
      logic [15:0] idx;
      logic [15:0] val;
      logic        in_frame;
   } item_type;

endpackage

// File: src/tpnc_if.sv
`timescale 1ns / 1ps
interface tpnc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [15:0] pixel_index;
   logic [15:0] pixel_value;
   modport source(output valid, mode, pixel_index, pixel_value, input ready);
   modport sink(input valid, mode, pixel_index, pixel_value, output ready);
endinterface

interface tpnc_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [15:0] corrected_pixel;
   logic        clipped;
   modport source(output valid, result_kind, corrected_pixel, clipped, input ready);
   modport sink(input valid, result_kind, corrected_pixel, clipped, output ready);
endinterface

// File: src/tpnc_front.sv
`timescale 1ns / 1ps
module tpnc_front #(
   parameter int unsigned FRAME_PIXELS = 65536
) (
   tpnc_req_if.sink             req_chan,
   input  logic                 clearing,
   input  logic                 full,
   output logic                 push,
   output tpnc_pkg::item_type   item
);
   import tpnc_pkg::*;

   localparam logic [31:0] PIXELS = 32'(FRAME_PIXELS);

   always_comb begin
      req_chan.ready = !full && !clearing;
      item.mode = mode_type'(req_chan.mode);
      item.idx = req_chan.pixel_index;
      item.val = req_chan.pixel_value;
      item.in_frame = {16'b0, req_chan.pixel_index} < PIXELS;
      // An unused mode is taken and dropped without a result.
      push = req_chan.valid && req_chan.ready && (item.mode != MODE_UNUSED);
   end

endmodule

// File: src/tpnc_queue.sv
`timescale 1ns / 1ps
module tpnc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tpnc_pkg::item_type push_item,
   input  logic               pop,
   output logic               full,
   output logic               valid,
   output tpnc_pkg::item_type head
);
   import tpnc_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      full = count_ff == 2'd2;
      valid = count_ff != 2'd0;
      head = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: src/tpnc_div.sv
`timescale 1ns / 1ps
module tpnc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [47:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [47:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [47:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [48:0] shifted;
   logic [49:0] trial;
   logic        ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      trial = {1'b0, shifted} - {2'b0, dvs_ff};
      ge = !trial[49];
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? trial[47:0] : shifted[47:0];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

// File: src/tpnc_back.sv
`timescale 1ns / 1ps
module tpnc_back #(
   parameter int unsigned FRAME_PIXELS = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  tpnc_pkg::item_type q_item,
   output logic               q_pop,
   output logic               clearing,
   tpnc_rsp_if.source         rsp_chan
);
   import tpnc_pkg::*;

   // The frame average is a multiply by a rounded-up reciprocal of the pixel count.
   localparam int unsigned AVG_L = $clog2(FRAME_PIXELS);
   localparam int unsigned AVG_SHIFT = 48 + AVG_L;
   localparam logic [99:0] AVG_RECIP = ((100'd1 << AVG_SHIFT) / 100'(FRAME_PIXELS)) + 100'd1;
   localparam logic [49:0] AVG_MUL = AVG_RECIP[49:0];

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_READ  = 8'b0000_0100,
      S_AVG_A = 8'b0000_1000,
      S_AVG_B = 8'b0001_0000,
      S_DIV   = 8'b0010_0000,
      S_MUL   = 8'b0100_0000,
      S_FIN   = 8'b1000_0000
   } state_type;

   logic [31:0] hot_mem  [DEPTH];
   logic [31:0] cold_mem [DEPTH];
   logic [15:0] gain_mem [DEPTH];
   logic [18:0] off_mem  [DEPTH];
   logic [15:0] flat_mem [DEPTH];

   state_type   state_ff, state_in;
   item_type    cur_ff, cur_in;
   logic [15:0] clr_cnt_ff, clr_cnt_in;
   logic        clr_flat_ff, clr_flat_in;
   logic [47:0] hot_total_ff, hot_total_in;
   logic [47:0] cold_total_ff, cold_total_in;
   logic [47:0] flat_total_ff, flat_total_in;
   logic [47:0] avg_ff, avg_in;
   logic [31:0] prod_ff, prod_in;
   logic [1:0]  mul_step_ff, mul_step_in;
   logic [97:0] mul_acc_ff, mul_acc_in;
   logic        res_kind_ff, res_kind_in;
   logic [15:0] res_pix_ff, res_pix_in;
   logic        res_clip_ff, res_clip_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [15:0] rsp_pix_ff, rsp_pix_in;
   logic        rsp_clip_ff, rsp_clip_in;

   logic [31:0] hot_rd_ff, cold_rd_ff;
   logic [15:0] gain_rd_ff, flat_rd_ff;
   logic [18:0] off_rd_ff;

   logic [15:0] wr_addr;
   logic        hot_we, cold_we, gain_we, off_we, flat_we;
   logic [31:0] hot_wd, cold_wd;
   logic [15:0] gain_wd, flat_wd;
   logic [18:0] off_wd;

   logic        div_start, div_done;
   logic [63:0] div_dividend, div_quo;
   logic [47:0] div_divisor;

   logic [47:0] mul_x;
   logic [23:0] mul_x_part;
   logic [24:0] mul_m_part;
   logic [48:0] mul_part;
   logic [97:0] mul_add;
   logic [97:0] mul_sum;
   logic [47:0] avg_now;

   logic               out_free;
   logic signed [48:0] num;
   logic signed [32:0] den;
   logic [47:0]        nmag;
   logic [32:0]        dmag;
   logic signed [34:0] acc;
   logic [15:0]        avg16;
   logic [18:0]        scaled;
   logic [19:0]        off_calc;

   tpnc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Four partial products of 24 by 25 bits, one per cycle.
   always_comb begin
      mul_x = (state_ff == S_AVG_B) ? cold_total_ff
            : (cur_ff.mode == MODE_MAKE_GAIN) ? hot_total_ff : flat_total_ff;
      mul_x_part = mul_step_ff[1] ? mul_x[47:24] : mul_x[23:0];
      mul_m_part = mul_step_ff[0] ? AVG_MUL[49:25] : AVG_MUL[24:0];
      mul_part = {25'b0, mul_x_part} * {24'b0, mul_m_part};
      case (mul_step_ff)
         2'd0: mul_add = {49'b0, mul_part};
         2'd1: mul_add = {24'b0, mul_part, 25'b0};
         2'd2: mul_add = {25'b0, mul_part, 24'b0};
         default: mul_add = {mul_part, 49'b0};
      endcase
      mul_sum = mul_acc_ff + mul_add;
      avg_now = 48'(mul_sum >> AVG_SHIFT);
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign clearing = state_ff == S_CLEAR;
   assign wr_addr = (state_ff == S_CLEAR) ? clr_cnt_ff : cur_ff.idx;

   assign num = $signed({1'b0, avg_ff}) - $signed({1'b0, avg_now});
   assign den = $signed({1'b0, hot_rd_ff}) - $signed({1'b0, cold_rd_ff});
   assign nmag = num[48] ? 48'(-num) : num[47:0];
   assign dmag = den[32] ? 33'(-den) : den;
   assign acc = $signed({3'b0, prod_ff}) + $signed({{2{off_rd_ff[18]}}, off_rd_ff, 14'b0})
                + 35'sd8192;
   assign avg16 = (|avg_now[47:16]) ? 16'hFFFF : avg_now[15:0];
   assign scaled = 19'(({1'b0, prod_ff} + 33'd8192) >> 14);
   assign off_calc = {4'b0, avg16} - {1'b0, scaled};

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      clr_cnt_in = clr_cnt_ff;
      clr_flat_in = clr_flat_ff;
      hot_total_in = hot_total_ff;
      cold_total_in = cold_total_ff;
      flat_total_in = flat_total_ff;
      avg_in = avg_ff;
      prod_in = prod_ff;
      mul_step_in = mul_step_ff;
      mul_acc_in = mul_acc_ff;
      res_kind_in = res_kind_ff;
      res_pix_in = res_pix_ff;
      res_clip_in = res_clip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in = rsp_kind_ff;
      rsp_pix_in = rsp_pix_ff;
      rsp_clip_in = rsp_clip_ff;
      hot_we = 1'b0;
      cold_we = 1'b0;
      gain_we = 1'b0;
      off_we = 1'b0;
      flat_we = 1'b0;
      hot_wd = '0;
      cold_wd = '0;
      gain_wd = '0;
      off_wd = '0;
      flat_wd = '0;
      div_start = 1'b0;
      div_dividend = '0;
      div_divisor = '0;
      q_pop = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            hot_we = 1'b1;
            cold_we = 1'b1;
            flat_we = clr_flat_ff;
            clr_cnt_in = clr_cnt_ff + 16'd1;
            if (clr_cnt_ff == 16'hFFFF) begin
               if (clr_flat_ff) begin
                  clr_flat_in = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  res_kind_in = KIND_DONE;
                  res_pix_in = '0;
                  res_clip_in = 1'b0;
                  state_in = S_FIN;
               end
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               cur_in = q_item;
               res_pix_in = '0;
               res_clip_in = 1'b0;
               res_kind_in = KIND_DONE;
               if (q_item.mode == MODE_CLEAR) begin
                  hot_total_in = '0;
                  cold_total_in = '0;
                  clr_cnt_in = '0;
                  state_in = S_CLEAR;
               end else if (!q_item.in_frame) begin
                  if (q_item.mode == MODE_CORRECT) begin
                     res_kind_in = KIND_PIXEL;
                     res_pix_in = q_item.val;
                  end
                  state_in = S_FIN;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_FIN;
            mul_step_in = '0;
            mul_acc_in = '0;
            case (cur_ff.mode)
               MODE_CORRECT: begin
                  prod_in = {16'b0, cur_ff.val} * {16'b0, gain_rd_ff};
                  state_in = S_MUL;
               end
               MODE_ADD_HOT: begin
                  hot_we = 1'b1;
                  hot_wd = hot_rd_ff + {16'b0, cur_ff.val};
                  hot_total_in = hot_total_ff + {32'b0, cur_ff.val};
               end
               MODE_ADD_COLD: begin
                  cold_we = 1'b1;
                  cold_wd = cold_rd_ff + {16'b0, cur_ff.val};
                  cold_total_in = cold_total_ff + {32'b0, cur_ff.val};
               end
               MODE_LOAD_FLAT: begin
                  flat_we = 1'b1;
                  flat_wd = cur_ff.val;
                  flat_total_in = flat_total_ff - {32'b0, flat_rd_ff} + {32'b0, cur_ff.val};
               end
               MODE_MAKE_GAIN: begin
                  state_in = S_AVG_A;
               end
               MODE_MAKE_OFFSET: begin
                  prod_in = {16'b0, gain_rd_ff} * {16'b0, flat_rd_ff};
                  state_in = S_AVG_A;
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_AVG_A: begin
            mul_acc_in = mul_sum;
            mul_step_in = mul_step_ff + 2'd1;
            if (mul_step_ff == 2'd3) begin
               avg_in = avg_now;
               mul_acc_in = '0;
               if (cur_ff.mode == MODE_MAKE_GAIN) begin
                  state_in = S_AVG_B;
               end else begin
                  off_we = 1'b1;
                  off_wd = off_calc[18:0];
                  state_in = S_FIN;
               end
            end
         end
         S_AVG_B: begin
            mul_acc_in = mul_sum;
            mul_step_in = mul_step_ff + 2'd1;
            if (mul_step_ff == 2'd3) begin
               state_in = S_FIN;
               if (den == 33'sd0) begin
                  gain_we = 1'b1;
                  gain_wd = (num > 49'sd0) ? GAIN_MAX : 16'd0;
               end else if ((num == 49'sd0) || (num[48] != den[32])) begin
                  gain_we = 1'b1;
                  gain_wd = 16'd0;
               end else begin
                  div_start = 1'b1;
                  div_dividend = {1'b0, nmag, 15'b0} + {31'b0, dmag};
                  div_divisor = {14'b0, dmag, 1'b0};
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               gain_we = 1'b1;
               gain_wd = (|div_quo[63:16]) ? GAIN_MAX : div_quo[15:0];
               state_in = S_FIN;
            end
         end
         S_MUL: begin
            res_kind_in = KIND_PIXEL;
            if (acc[34]) begin
               res_pix_in = '0;
               res_clip_in = 1'b1;
            end else if (|acc[33:30]) begin
               res_pix_in = 16'hFFFF;
               res_clip_in = 1'b1;
            end else begin
               res_pix_in = acc[29:14];
               res_clip_in = 1'b0;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = res_kind_ff;
               rsp_pix_in = res_pix_ff;
               rsp_clip_in = res_clip_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.result_kind = rsp_kind_ff;
   assign rsp_chan.corrected_pixel = rsp_pix_ff;
   assign rsp_chan.clipped = rsp_clip_ff;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         hot_rd_ff <= hot_mem[q_item.idx];
      end
      if (hot_we) begin
         hot_mem[wr_addr] <= hot_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cold_rd_ff <= cold_mem[q_item.idx];
      end
      if (cold_we) begin
         cold_mem[wr_addr] <= cold_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         gain_rd_ff <= gain_mem[q_item.idx];
      end
      if (gain_we) begin
         gain_mem[wr_addr] <= gain_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         off_rd_ff <= off_mem[q_item.idx];
      end
      if (off_we) begin
         off_mem[wr_addr] <= off_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         flat_rd_ff <= flat_mem[q_item.idx];
      end
      if (flat_we) begin
         flat_mem[wr_addr] <= flat_wd;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      avg_ff <= avg_in;
      prod_ff <= prod_in;
      mul_step_ff <= mul_step_in;
      mul_acc_ff <= mul_acc_in;
      res_kind_ff <= res_kind_in;
      res_pix_ff <= res_pix_in;
      res_clip_ff <= res_clip_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_pix_ff <= rsp_pix_in;
      rsp_clip_ff <= rsp_clip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_cnt_ff <= '0;
         clr_flat_ff <= 1'b1;
         hot_total_ff <= '0;
         cold_total_ff <= '0;
         flat_total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         clr_flat_ff <= clr_flat_in;
         hot_total_ff <= hot_total_in;
         cold_total_ff <= cold_total_in;
         flat_total_ff <= flat_total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A calibration step never reports a pixel value or a clip.
   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_DONE) |-> (rsp_pix_ff == 16'd0 && !rsp_clip_ff))
      else $error("calibration result carries pixel data");

   // No transaction leaves the queue while the sums are being swept.
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !q_pop)
      else $error("queue popped during clearing pass");

   // A finished result waits while the output register is still occupied.
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && !out_free) |=> (state_ff == S_FIN))
      else $error("result lost while output stalled");

   // The divider is only started from a state that waits for it.
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (state_ff == S_DIV))
      else $error("divider started without a waiting state");

endmodule

// File: src/two_point_nuc_calibrate_correct.sv
`timescale 1ns / 1ps
// Channel    Direction  Transaction
// req_chan   in         mode, pixel_index, pixel_value
// rsp_chan   out        result_kind, corrected_pixel, clipped
//
// Items are handled one at a time by the back end behind a two-entry queue.
// A correction passes the back end through pop, table read, multiply and output.
// Add hot, add cold and load flat read the tables, then write back.
// Make offset takes the frame average by reciprocal multiply, then writes the offset.
// Make gain may run its quotient through the 64-step divider.
// After reset, and for each clear-sums item, a clearing pass over every table address
// zeroes the sum memories (and after reset the flat frame); no item is taken
// during a pass. Results wait in an output register.
module two_point_nuc_calibrate_correct #(
   parameter int unsigned FRAME_WIDTH = 256,
   parameter int unsigned FRAME_HEIGHT = 256
) (
   input  logic       clock,
   input  logic       reset,
   tpnc_req_if.sink   req_chan,
   tpnc_rsp_if.source rsp_chan
);
   import tpnc_pkg::*;

   localparam int unsigned FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;

   item_type push_item, head_item;
   logic     push, pop, full, q_valid, clearing;

   tpnc_front #(
      .FRAME_PIXELS (FRAME_PIXELS)
   ) u_front (
      .req_chan (req_chan),
      .clearing (clearing),
      .full     (full),
      .push     (push),
      .item     (push_item)
   );

   tpnc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (full),
      .valid     (q_valid),
      .head      (head_item)
   );

   tpnc_back #(
      .FRAME_PIXELS (FRAME_PIXELS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (head_item),
      .q_pop    (pop),
      .clearing (clearing),
      .rsp_chan (rsp_chan)
   );

endmodule
